>>> rtl/blr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the line rasterizer.
// No dependencies; used by every module of the block.
package blr_pkg;

  localparam int COORD_W  = 6;   // port width of one coordinate
  localparam int COLOR_W  = 16;
  localparam int SCREEN_W = 7;   // width of the screen size registers
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;

  localparam logic [SCREEN_W-1:0] SCREEN_RESET = 7'd64;

  typedef struct packed {
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
    logic [COLOR_W-1:0] pixel_color;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [COLOR_W-1:0] out_color;
    logic               visible;
    logic               last;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;    // capture the line command
    logic setup;   // compute spans, ordering and initial error
    logic step;    // advance to the next point
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last_point;
  } dp_status_t;

endpackage

>>> rtl/blr_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the line rasterizer: idle, setup, point generation.
// Depends on blr_pkg for the command and status structs.
module blr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  blr_pkg::dp_status_t status,
  output blr_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SETUP = 3'b010,
    ST_RUN   = 3'b100
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        // no command is taken while reset is held
        in_ready = ~rst;
        if (in_valid && !rst) begin
          cmd.load   = 1'b1;
          state_next = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = ST_RUN;
      end
      ST_RUN: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.step = 1'b1;
          if (status.last_point) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/blr_datapath.sv
`timescale 1ns / 1ps
// Bresenham datapath: command capture, span setup, point/error update, clipping.
// Depends on blr_pkg for the item and command types.
module blr_datapath #(
  parameter int COORD_BITS = 6
) (
  input  logic                             clk,
  input  blr_pkg::ctrl_cmd_t               cmd,
  output blr_pkg::dp_status_t              status,
  input  blr_pkg::in_item_t                in_data,
  input  logic [blr_pkg::SCREEN_W-1:0]     screen_width,
  input  logic [blr_pkg::SCREEN_W-1:0]     screen_height,
  output blr_pkg::out_item_t               out_data
);

  localparam int CB = COORD_BITS;
  localparam int EW = COORD_BITS + 2;   // signed error term

  // captured command
  logic [CB-1:0]               sx, sy, ex, ey;
  logic [blr_pkg::COLOR_W-1:0] color;

  // walk state
  logic [CB-1:0] m, m_end, n, d, minor;
  logic [EW-1:0] err;
  logic          up, steep;

  // setup terms
  logic [CB:0]   dx, dy;
  logic [CB-1:0] adx, ady;
  logic          steep_c, swap_c;
  logic [CB-1:0] a_maj, a_min, b_maj, b_min;
  logic [CB-1:0] m0, m_end0, n0, n_end0, span_maj, span_min;

  always_comb begin
    dx       = {1'b0, ex} - {1'b0, sx};
    dy       = {1'b0, ey} - {1'b0, sy};
    adx      = dx[CB] ? CB'(~dx + 1'b1) : dx[CB-1:0];
    ady      = dy[CB] ? CB'(~dy + 1'b1) : dy[CB-1:0];
    steep_c  = ady > adx;
    a_maj    = steep_c ? sy : sx;
    a_min    = steep_c ? sx : sy;
    b_maj    = steep_c ? ey : ex;
    b_min    = steep_c ? ex : ey;
    swap_c   = a_maj > b_maj;
    m0       = swap_c ? b_maj : a_maj;
    m_end0   = swap_c ? a_maj : b_maj;
    n0       = swap_c ? b_min : a_min;
    n_end0   = swap_c ? a_min : b_min;
    span_maj = steep_c ? ady : adx;
    span_min = steep_c ? adx : ady;
  end

  // error update for one step; sign bit selects the minor move
  logic [EW-1:0] err_sub;
  assign err_sub = err - {2'b00, minor};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sx    <= in_data.start_x[CB-1:0];
      sy    <= in_data.start_y[CB-1:0];
      ex    <= in_data.end_x[CB-1:0];
      ey    <= in_data.end_y[CB-1:0];
      color <= in_data.pixel_color;
    end
    if (cmd.setup) begin
      m     <= m0;
      m_end <= m_end0;
      n     <= n0;
      up    <= n0 < n_end0;
      steep <= steep_c;
      d     <= span_maj;
      minor <= span_min;
      err   <= {3'b000, span_maj[CB-1:1]};
    end else if (cmd.step) begin
      m <= m + 1'b1;
      if (err_sub[EW-1]) begin
        n   <= up ? n + 1'b1 : n - 1'b1;
        err <= err_sub + {2'b00, d};
      end else begin
        err <= err_sub;
      end
    end
  end

  logic [CB-1:0]               px, py;
  logic [blr_pkg::COORD_W-1:0] px_ext, py_ext;

  always_comb begin
    px     = steep ? n : m;
    py     = steep ? m : n;
    px_ext = blr_pkg::COORD_W'(px);
    py_ext = blr_pkg::COORD_W'(py);
    status.last_point  = (m == m_end);
    out_data.pixel_x   = px_ext;
    out_data.pixel_y   = py_ext;
    out_data.out_color = color;
    out_data.visible   = (blr_pkg::SCREEN_W'(px_ext) < screen_width) &&
                         (blr_pkg::SCREEN_W'(py_ext) < screen_height);
    out_data.last      = status.last_point;
  end

endmodule

>>> rtl/bresenham_line_rasterizer.sv
`timescale 1ns / 1ps
// Bresenham line rasterizer, top level. Depends on blr_pkg, blr_ctrl, blr_datapath.
// First point: valid after the command is accepted and the setup state has loaded
//   the walk registers.
// Throughput: one point per cycle while out_ready is high; a new command is
//   taken only after the last point of the line has been accepted.
// Reset (rst, synchronous): sequencer idle with in_ready low while rst is held,
//   screen width and height back to 64.
module bresenham_line_rasterizer #(
  parameter int COORD_BITS = 6   // coordinates taken modulo 2^COORD_BITS, 4..6
) (
  input  logic                               clk,
  input  logic                               rst,
  // line commands
  input  logic                               in_valid,
  output logic                               in_ready,
  input  blr_pkg::in_item_t                  in_data,
  // generated points
  output logic                               out_valid,
  input  logic                               out_ready,
  output blr_pkg::out_item_t                 out_data,
  // configuration writes
  input  logic                               cfg_wr_en,
  input  logic [blr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [blr_pkg::SCREEN_W-1:0]       cfg_data
);

  // Screen size registers. Unknown indexes are ignored.
  logic [blr_pkg::SCREEN_W-1:0] screen_width, screen_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= blr_pkg::SCREEN_RESET;
      screen_height <= blr_pkg::SCREEN_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        blr_pkg::CFG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        blr_pkg::CFG_SCREEN_HEIGHT: screen_height <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  blr_pkg::ctrl_cmd_t  cmd;
  blr_pkg::dp_status_t status;

  // Sequencer: takes a command in idle, passes through a setup state, then walks the
  // line one point per accepted output item.
  blr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath: points come straight from the walk registers; clipping only
  // flags a point, it never drops one.
  blr_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk           (clk),
    .cmd           (cmd),
    .status        (status),
    .in_data       (in_data),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .out_data      (out_data)
  );

endmodule
